[design/wtec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Web text escape codec package
// Shared transaction types, mode codes and output job encoding for the
// front classifier, the job queue and the back expander.
// ----------------------------------------------------------------------------
package wtec_pkg;

   // Mode register codes.
   localparam logic [1:0] MODE_URL_ENCODE = 2'd0;
   localparam logic [1:0] MODE_URL_DECODE = 2'd1;
   localparam logic [1:0] MODE_XML_ESCAPE = 2'd2;

   // Width of the per-job output index; a job emits at most six bytes.
   localparam int unsigned IDX_W = 3;

   // Input transaction payload.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   // Result transaction payload.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       out_last;
   } rsp_item_type;

   // URL decode progress through a percent escape.
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   // What the back end has to emit for one queued job.
   typedef enum logic [2:0] {
      JOB_BYTE = 3'd0,
      JOB_HEX  = 3'd1,
      JOB_QUOT = 3'd2,
      JOB_AMP  = 3'd3,
      JOB_LT   = 3'd4,
      JOB_GT   = 3'd5,
      JOB_END  = 3'd6
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } job_type;

   // Character constants.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_LESS    = 8'h3c;
   localparam logic [7:0] CH_GREATER = 8'h3e;

   localparam logic [15:0][7:0] HEX_DIGITS = "0123456789abcdef";
   localparam logic [5:0][7:0]  ENT_QUOT   = "&quot;";
   localparam logic [4:0][7:0]  ENT_AMP    = "&amp;";
   localparam logic [3:0][7:0]  ENT_LT     = "&lt;";
   localparam logic [3:0][7:0]  ENT_GT     = "&gt;";

   // Bytes that URL encoding passes through unchanged.
   function automatic logic keep_plain(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
             (c >= 8'h41 && c <= 8'h5a) || c == 8'h2d || c == 8'h5f ||
             c == 8'h2e || c == 8'h7e;
   endfunction

   // Hex digit value; non-hex characters wrap modulo 256.
   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] lower;
      lower = c;
      if (c >= 8'h30 && c <= 8'h39) begin
         return c - 8'h30;
      end
      if (c >= 8'h41 && c <= 8'h5a) begin
         lower = c + 8'h20;
      end
      return lower - 8'h57;
   endfunction

   // Number of result bytes a job produces.
   function automatic logic [IDX_W-1:0] job_length(input job_kind_type kind);
      case (kind)
         JOB_HEX:  return 3'd3;
         JOB_QUOT: return 3'd6;
         JOB_AMP:  return 3'd5;
         JOB_LT:   return 3'd4;
         JOB_GT:   return 3'd4;
         default:  return 3'd1;
      endcase
   endfunction

   // Byte at position idx of a job's expansion.
   function automatic logic [7:0] job_char(input job_type job,
                                           input logic [IDX_W-1:0] idx);
      logic [7:0] res;
      res = job.data;
      case (job.kind)
         JOB_HEX: begin
            if (idx == 3'd0) begin
               res = CH_PERCENT;
            end else if (idx == 3'd1) begin
               res = HEX_DIGITS[4'd15 - job.data[7:4]];
            end else begin
               res = HEX_DIGITS[4'd15 - job.data[3:0]];
            end
         end
         JOB_QUOT: res = ENT_QUOT[3'd5 - idx];
         JOB_AMP:  res = ENT_AMP[3'd4 - idx];
         JOB_LT:   res = ENT_LT[2'(3'd3 - idx)];
         JOB_GT:   res = ENT_GT[2'(3'd3 - idx)];
         JOB_END:  res = 8'h00;
         default:  res = job.data;
      endcase
      return res;
   endfunction

endpackage

[design/web_text_escape_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Web text escape codec
// URL encode, URL decode or XML entity escape of a byte string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present req_item with push; a transaction is taken at a
//   clock edge where push is high and full is low. Mark the final byte of a
//   string with in_last.
//   Result channel: while empty is low, rsp_item holds the oldest result;
//   pop high at a clock edge takes it. out_last marks the string's final
//   result; byte_valid low marks a bare end marker with no data.
//   Configuration: csr_wr_en writes csr_wr_data into the mode register; write
//   only while the block is idle.
//   Result path: the first result of an input byte is registered in the job
//   queue, then in the back end's current-job register, if the result side is free.
//   Throughput: one result byte per cycle while pop is high and jobs wait,
//   set by the single result port; an input byte yields 0 to 6 results (6
//   for a quote escape). Input bytes keep flowing into the job queue while
//   earlier results expand. Reset: mode returns to URL encode, the decoder
//   goes idle, queue empties. When the receiver stalls, results hold; once
//   the job queue fills, full rises and input stops.
// ----------------------------------------------------------------------------
module web_text_escape_codec
   import wtec_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   logic    job_push, job_pop, job_full, job_empty;
   job_type job_wr, job_rd;

   assign full = job_full;

   wtec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .req_item    (req_item),
      .job_full    (job_full),
      .job_push    (job_push),
      .job         (job_wr)
   );

   wtec_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_push),
      .wr_job (job_wr),
      .full   (job_full),
      .rd_en  (job_pop),
      .rd_job (job_rd),
      .empty  (job_empty)
   );

   wtec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

[design/wtec_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Web text escape codec front end
// Holds the mode register and URL decode state, classifies each accepted
// input transaction and queues at most one output job for it.
// ----------------------------------------------------------------------------
module wtec_front
   import wtec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   input  logic         push,
   input  req_item_type req_item,
   input  logic         job_full,
   output logic         job_push,
   output job_type      job
);

   logic [1:0] mode_ff;
   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       emit;
   logic [7:0] c;
   logic [7:0] held_val;

   assign accept = push && !job_full;
   assign c      = req_item.in_byte;

   // Value of the held first digit of an escape.
   assign held_val = hex_value(held_ff);

   // Classify the byte into a job and advance the decode state.
   always_comb begin
      emit     = 1'b0;
      job.kind = JOB_BYTE;
      job.data = c;
      job.last = req_item.in_last;
      phase_in = phase_ff;
      held_in  = held_ff;
      case (mode_ff)
         MODE_URL_ENCODE: begin
            emit = 1'b1;
            if (keep_plain(c)) begin
               job.kind = JOB_BYTE;
            end else if (c == CH_SPACE) begin
               job.data = CH_PLUS;
            end else begin
               job.kind = JOB_HEX;
            end
         end
         MODE_URL_DECODE: begin
            case (phase_ff)
               PH_DIGIT: begin
                  emit     = 1'b1;
                  job.data = {held_val[3:0], 4'b0000} | hex_value(c);
                  phase_in = PH_IDLE;
               end
               PH_PERCENT: begin
                  if (req_item.in_last) begin
                     emit     = (c != CH_PERCENT);
                     job.data = (c == CH_PLUS) ? CH_SPACE : c;
                     phase_in = PH_IDLE;
                  end else begin
                     held_in  = c;
                     phase_in = PH_DIGIT;
                  end
               end
               default: begin
                  if (c == CH_PERCENT) begin
                     if (!req_item.in_last) begin
                        phase_in = PH_PERCENT;
                     end
                  end else begin
                     emit     = 1'b1;
                     job.data = (c == CH_PLUS) ? CH_SPACE : c;
                  end
               end
            endcase
         end
         MODE_XML_ESCAPE: begin
            emit = 1'b1;
            case (c)
               CH_QUOTE:   job.kind = JOB_QUOT;
               CH_AMP:     job.kind = JOB_AMP;
               CH_LESS:    job.kind = JOB_LT;
               CH_GREATER: job.kind = JOB_GT;
               default:    job.kind = JOB_BYTE;
            endcase
         end
         default: begin
            emit = 1'b1;
         end
      endcase
      // A final byte always closes the string, with a bare marker if needed.
      if (req_item.in_last) begin
         if (!emit) begin
            emit     = 1'b1;
            job.kind = JOB_END;
         end
         phase_in = PH_IDLE;
         held_in  = 8'h00;
      end
   end

   assign job_push = accept && emit;

   // Mode register and decode state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_URL_ENCODE;
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
         end
      end
   end

   // A string end always leaves the decoder idle and cleared.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_item.in_last |=> phase_ff == PH_IDLE && held_ff == 8'h00)
      else $error("decode state not cleared after final byte");

   // Every final byte queues a job carrying the last flag.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_item.in_last |-> job_push && job.last)
      else $error("final byte produced no closing job");

endmodule

[design/wtec_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Web text escape codec job queue
// Small first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module wtec_fifo
   import wtec_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   output logic    full,
   input  logic    rd_en,
   output job_type rd_job,
   output logic    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr, do_rd;

   assign full   = (count_ff == FULL_CNT);
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_job = store[rd_ptr_ff];

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         store[wr_ptr_ff] <= wr_job;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Occupancy never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("job queue overflow");

endmodule

[design/wtec_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Web text escape codec back end
// Expands queued jobs into result bytes, one per cycle while popped and fed.
// ----------------------------------------------------------------------------
module wtec_back
   import wtec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_empty,
   input  job_type      job,
   output logic         job_pop,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   job_type          cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] len;
   logic             at_end;
   logic             take;

   assign len    = job_length(cur_ff.kind);
   assign at_end = (idx_ff == len - 1'b1);
   assign empty  = !cur_valid_ff;

   // Result transaction from the current job and position.
   assign rsp_item.out_byte   = job_char(cur_ff, idx_ff);
   assign rsp_item.byte_valid = (cur_ff.kind != JOB_END);
   assign rsp_item.out_last   = cur_ff.last && at_end;

   // Step through the job; fetch the next one as the current one finishes.
   always_comb begin
      take         = !cur_valid_ff || (pop && at_end);
      job_pop      = take && !job_empty;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (take) begin
         cur_in       = job;
         cur_valid_in = !job_empty;
         idx_in       = '0;
      end else if (pop) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // The position stays inside the current job's expansion.
   assert property (@(posedge clock) disable iff (reset) cur_valid_ff |-> idx_ff < len)
      else $error("expansion index out of range");

   // A bare end marker is always the last result of its string.
   assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_item.byte_valid |-> rsp_item.out_last)
      else $error("bare end marker without last flag");

endmodule
